[rtl/dgcs_pkg.sv]
// shared types and constants for the datagram checksum receiver
package dgcs_pkg;

  localparam int unsigned MAX_PACKET_DEF = 1024;
  localparam int unsigned HDR_BYTES      = 6;
  localparam int unsigned SUM_W          = 16;
  localparam int unsigned LEN_W          = 10;
  localparam logic [SUM_W-1:0] SUM_MASK  = 16'hFFFF;

  // header byte positions
  localparam int unsigned OFF_LEN_HI = 0;
  localparam int unsigned OFF_LEN_LO = 1;
  localparam int unsigned OFF_CSUM_LO = 2;
  localparam int unsigned OFF_CSUM_HI = 3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_LEN_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             packet_done;
    status_t          status;
    logic [LEN_W-1:0] payload_length;
  } out_item_t;

  // ones-complement add of two 16-bit values, end-around carry folded back
  function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

[rtl/datagram_checksum_receiver.sv]
// top level: input register, checksum core and result register with handshake
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless stalled; one add-and-fold per byte in the core
// a full result register is freed in the cycle it is taken, so stalls cost no bubbles
// reset: synchronous active-low rst_n empties both registers and zeroes packet state
module datagram_checksum_receiver #(
  parameter int unsigned MAX_PACKET = dgcs_pkg::MAX_PACKET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dgcs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dgcs_pkg::out_item_t out_item
);

  // input register
  logic                in_vld_r;
  dgcs_pkg::in_item_t  in_item_r;
  // result register
  logic                out_vld_r;
  dgcs_pkg::out_item_t out_item_r;

  logic                adv;
  dgcs_pkg::out_item_t res;

  // an item moves into the result register when that register is empty or being taken
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  // the input register refills in the same cycle it drains
  assign in_stall = in_vld_r && !adv;

  dgcs_core #(
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not filled after advance");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(out_item_r))
    else $error("stalled result lost or changed");

endmodule

[rtl/dgcs_core.sv]
// per-packet state, checksum accumulation and status decision
module dgcs_core #(
  parameter int unsigned MAX_PACKET = dgcs_pkg::MAX_PACKET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dgcs_pkg::in_item_t  item,
  output dgcs_pkg::out_item_t res
);

  localparam int unsigned OFF_W = $clog2(MAX_PACKET + 1);
  localparam int unsigned CW    = ((OFF_W > 16) ? OFF_W : 16) + 1;
  localparam int unsigned SW    = dgcs_pkg::SUM_W;

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [15:0]      csum_r, csum_nxt;
  logic [15:0]      dlen_r, dlen_nxt;

  logic             in_range;
  logic [7:0]       w;
  logic [SW-1:0]    sum_step, sum_fin;
  logic [CW-1:0]    off_ext, cnt_ext, dlen_ext, hdr_ext;
  logic [SW-1:0]    calc;
  dgcs_pkg::status_t st;

  always_comb begin
    off_nxt  = off_r;
    sum_step = sum_r;
    pend_nxt = pend_r;
    csum_nxt = csum_r;
    dlen_nxt = dlen_r;
    in_range = (off_r < OFF_W'(MAX_PACKET));
    off_ext  = CW'(off_r);
    hdr_ext  = CW'(dgcs_pkg::HDR_BYTES);
    dlen_ext = CW'(dlen_r);
    w        = item.rx_byte;
    res      = '0;
    res.status = dgcs_pkg::STATUS_OK;

    if (in_range) begin
      if (off_r == OFF_W'(dgcs_pkg::OFF_LEN_HI)) begin
        dlen_nxt = {item.rx_byte, 8'h00};
      end else if (off_r == OFF_W'(dgcs_pkg::OFF_LEN_LO)) begin
        dlen_nxt = dlen_r | {8'h00, item.rx_byte};
      end else if (off_r == OFF_W'(dgcs_pkg::OFF_CSUM_LO)) begin
        csum_nxt = {8'h00, item.rx_byte};
      end else if (off_r == OFF_W'(dgcs_pkg::OFF_CSUM_HI)) begin
        csum_nxt = csum_r | {item.rx_byte, 8'h00};
      end
      // checksum field counts as zero
      if (off_r == OFF_W'(dgcs_pkg::OFF_CSUM_LO) ||
          off_r == OFF_W'(dgcs_pkg::OFF_CSUM_HI)) begin
        w = 8'h00;
      end
      if (!off_r[0]) begin
        pend_nxt = w;
      end else begin
        sum_step = dgcs_pkg::oc_add(sum_r, {w, pend_r});
      end
      if (off_ext >= hdr_ext && (off_ext - hdr_ext) < dlen_ext) begin
        res.payload_byte  = item.rx_byte;
        res.payload_valid = 1'b1;
      end
      off_nxt = off_r + OFF_W'(1);
    end

    cnt_ext = CW'(off_nxt);
    // odd trailing byte goes in alone as a low byte
    sum_fin = off_nxt[0] ? dgcs_pkg::oc_add(sum_step, {8'h00, pend_nxt}) : sum_step;
    calc    = ~sum_fin & dgcs_pkg::SUM_MASK;

    if (cnt_ext < hdr_ext) begin
      st = dgcs_pkg::STATUS_LEN_ERR;
    end else if (calc != csum_nxt) begin
      st = dgcs_pkg::STATUS_CSUM_ERR;
    end else if (CW'(dlen_nxt) > (cnt_ext - hdr_ext)) begin
      st = dgcs_pkg::STATUS_LEN_ERR;
    end else begin
      st = dgcs_pkg::STATUS_OK;
    end

    sum_nxt = sum_step;
    if (item.is_last) begin
      res.packet_done = 1'b1;
      res.status      = st;
      if (st == dgcs_pkg::STATUS_OK) begin
        res.payload_length = dlen_nxt[dgcs_pkg::LEN_W-1:0];
      end
      off_nxt  = '0;
      sum_nxt  = '0;
      pend_nxt = '0;
      csum_nxt = '0;
      dlen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      sum_r  <= '0;
      pend_r <= '0;
      csum_r <= '0;
      dlen_r <= '0;
    end else if (step) begin
      off_r  <= off_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      csum_r <= csum_nxt;
      dlen_r <= dlen_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.is_last |=> off_r == '0 && sum_r == '0 && dlen_r == '0)
    else $error("packet state not cleared after last item");

  a_off_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= OFF_W'(MAX_PACKET))
    else $error("byte offset beyond maximum packet size");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    !res.packet_done |-> res.status == dgcs_pkg::STATUS_OK && res.payload_length == '0)
    else $error("status reported without packet end");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res.payload_valid |-> res.payload_byte == 8'h00)
    else $error("payload byte not zero when invalid");

endmodule
